/* sv/assert_macros.svh */
// Assertion macros used by the RTL file table_sine_vector_rotate.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* sv/tsvr_pkg.sv */
// Types, constants, cosine table and angle split helper for the sine rotator.
`timescale 1ns / 1ps
package tsvr_pkg;

    localparam int ANGLE_W  = 32;
    localparam int XY_OUT_W = 20;
    localparam int TRIG_W   = 15;
    localparam int ROM_W    = 14;
    localparam int DEG_W    = 7;
    localparam int TENTH_W  = 4;
    localparam int RED_W    = 12;
    localparam int FOLD_W   = 10;
    localparam int LIN_W    = 17;
    localparam int M_TDATA_W = 72;

    // angle reduction: offset of 2^31 mod 3600, divisor 3600 = 16 * 225
    localparam logic [RED_W-1:0]   RED_OFS      = 12'd848;
    localparam logic [RED_W-1:0]   RED_WRAP     = 12'd2752;   // 3600 - 848
    localparam logic [RED_W-1:0]   COS_SHIFT    = 12'd1748;   // 900 + 848
    localparam logic [RED_W:0]     COS_SHIFT_HI = 13'd5348;   // 1748 + 3600
    localparam logic [27:0]        DIV225       = 28'd225;
    localparam logic [28:0]        RECIP225     = 29'd305419897; // ceil(2^36/225)
    localparam int                 RECIP225_SH  = 36;

    localparam logic [RED_W-1:0]   FULL_TURN    = 12'd3600;
    localparam logic [RED_W-1:0]   THREE_QUART  = 12'd2700;
    localparam logic [RED_W-1:0]   HALF_TURN    = 12'd1800;
    localparam logic [RED_W-1:0]   QUART_TURN   = 12'd900;

    // divide by ten for values up to 900
    localparam logic [17:0]        RECIP10      = 18'd205;
    localparam logic [FOLD_W-1:0]  TEN          = 10'd10;
    localparam logic [DEG_W-1:0]   LAST_DEG     = 7'd90;
    localparam logic [TENTH_W-1:0] LAST_TENTH   = 4'd9;

    // interpolation term: (lin + 286) / 573
    localparam logic [LIN_W-1:0]   LIN_RND      = 17'd286;
    localparam logic [LIN_W-1:0]   LIN_RECIP    = 17'd117119; // ceil(2^26/573)
    localparam int                 LIN_SH       = 26;

    localparam int                 TRIG_MAX     = 10001;

    // rotation output: /10000 = >>4 then /625
    localparam int                 XY_DIV       = 625;

    typedef struct packed {
        logic               neg;
        logic [DEG_W-1:0]   deg;
        logic [TENTH_W-1:0] tenth;
    } trig_idx_t;

    localparam logic [ROM_W-1:0] COS_ROM [0:90] = '{
        14'd10000, 14'd9998, 14'd9994, 14'd9986, 14'd9976, 14'd9962, 14'd9945,
        14'd9925, 14'd9903, 14'd9877, 14'd9848, 14'd9816, 14'd9781, 14'd9744,
        14'd9703, 14'd9659, 14'd9613, 14'd9563, 14'd9511, 14'd9455, 14'd9397,
        14'd9336, 14'd9272, 14'd9205, 14'd9135, 14'd9063, 14'd8988, 14'd8910,
        14'd8829, 14'd8746, 14'd8660, 14'd8572, 14'd8480, 14'd8387, 14'd8290,
        14'd8192, 14'd8090, 14'd7986, 14'd7880, 14'd7771, 14'd7660, 14'd7547,
        14'd7431, 14'd7314, 14'd7193, 14'd7071, 14'd6947, 14'd6820, 14'd6691,
        14'd6561, 14'd6428, 14'd6293, 14'd6157, 14'd6018, 14'd5878, 14'd5736,
        14'd5592, 14'd5446, 14'd5299, 14'd5150, 14'd5000, 14'd4848, 14'd4695,
        14'd4540, 14'd4384, 14'd4226, 14'd4067, 14'd3907, 14'd3746, 14'd3584,
        14'd3420, 14'd3256, 14'd3090, 14'd2924, 14'd2756, 14'd2588, 14'd2419,
        14'd2250, 14'd2079, 14'd1908, 14'd1736, 14'd1564, 14'd1392, 14'd1219,
        14'd1045, 14'd872,  14'd698,  14'd523,  14'd349,  14'd175,  14'd0
    };

    // fold 0..3599 into the first quadrant, then split into degree and tenth
    function automatic trig_idx_t split_angle(input logic [RED_W-1:0] r);
        logic [RED_W-1:0]  f;
        logic [17:0]       prod;
        logic [FOLD_W-1:0] diff;
        trig_idx_t         o;
        if (r > THREE_QUART) begin
            f = FULL_TURN - r;
        end else if (r > HALF_TURN) begin
            f = r - HALF_TURN;
        end else if (r > QUART_TURN) begin
            f = HALF_TURN - r;
        end else begin
            f = r;
        end
        prod    = {8'd0, f[FOLD_W-1:0]} * RECIP10;
        o.neg   = (r > HALF_TURN);
        o.deg   = prod[17:11];
        diff    = f[FOLD_W-1:0] - ({3'd0, o.deg} * TEN);
        o.tenth = diff[TENTH_W-1:0];
        return o;
    endfunction

endpackage

/* sv/table_sine_vector_rotate.sv */
// Pipelined table sine/cosine and point rotation, top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   Slave channel s_*: one request per accepted beat carries an angle in
//   tenths of a degree (any 32-bit value) and a point x_in, y_in.
//   Master channel m_*: one result per request, in order: the point rotated
//   anticlockwise by the angle and the sine and cosine of the angle, both
//   scaled by 10000 (table values with linear interpolation on the tenths).
//   Rotated coordinates are divided by 10000, truncated toward zero and
//   kept to 20 bits.
// Timing
//   12 register stages: a result shows on m_tvalid once its request has
//   passed all of them. One request per cycle is sustained while m_tready
//   is high; the depth is set by the two reciprocal multiplies of the angle
//   reduction and of the final /10000, which is cut into partial products.
// Flow control
//   Each stage holds a valid bit. A stage loads when it is empty or when
//   the stage after it loads, so bubbles collapse and s_tready stays high
//   while results wait, until every stage is full. A stall of m_tready
//   freezes full stages back to the first empty one; nothing is dropped or repeated.
// Reset
//   aresetn low clears all valid bits and holds s_tready low.
module table_sine_vector_rotate #(
    parameter int COORD_WIDTH = 18,
    localparam int S_TDATA_W = ((tsvr_pkg::ANGLE_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // angle[31:0], x_in[COORD_WIDTH], y_in[COORD_WIDTH], zero pad
    input  logic [S_TDATA_W-1:0]           s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // x_out[19:0], y_out[39:20], sine[54:40], cosine[69:55], zero pad
    output logic [tsvr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int NSTG  = 12;
    localparam int W     = COORD_WIDTH;
    localparam int PW    = W + tsvr_pkg::TRIG_W;       // one product
    localparam int SW    = PW + 1;                     // sum of two products
    localparam int MAG_W = W + 14;                     // |sum| < 10001 * 2^W
    localparam int VW    = MAG_W - 4;                  // |sum| >> 4
    localparam int RW    = VW + 1;                     // reciprocal of 625
    localparam int K_DIV = VW + 10;
    localparam int VL    = VW / 2;
    localparam int VH    = VW - VL;
    localparam int RL    = RW / 2;
    localparam int RH    = RW - RL;
    localparam int PRW   = VW + RW;
    localparam int QW    = PRW - K_DIV;
    localparam int QX    = (QW + 1 > tsvr_pkg::XY_OUT_W) ? QW + 1 : tsvr_pkg::XY_OUT_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << K_DIV) + 64'(tsvr_pkg::XY_DIV) - 64'd1) / 64'(tsvr_pkg::XY_DIV);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    // ---------------- handshake and valid chain ----------------
    logic [NSTG:1]   vld_reg;
    logic [NSTG:1]   vld_in;
    logic [NSTG+1:1] en;
    logic            in_acc;
    logic            out_acc;

    always_comb begin
        en[NSTG+1] = m_tready;
        for (int i = NSTG; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_in   = {vld_reg[NSTG-1:1], s_tvalid};
    assign s_tready = en[1] && aresetn;
    assign m_tvalid = vld_reg[NSTG];
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // ---------------- input fields ----------------
    logic [tsvr_pkg::ANGLE_W-1:0] angle;
    logic signed [W-1:0]          x_in;
    logic signed [W-1:0]          y_in;
    logic [31:0]                  ang_u;

    assign angle = s_tdata[tsvr_pkg::ANGLE_W-1:0];
    assign x_in  = s_tdata[tsvr_pkg::ANGLE_W +: W];
    assign y_in  = s_tdata[tsvr_pkg::ANGLE_W + W +: W];
    assign ang_u = {~angle[31], angle[30:0]};   // angle + 2^31, unsigned

    // ---------------- stage 1: reciprocal multiply for /3600 ----------------
    logic [27:0]         v1_reg, v1_next;
    logic [3:0]          ulo1_reg, ulo1_next;
    logic [56:0]         p1_reg, p1_next;
    logic signed [W-1:0] x1_reg, y1_reg;

    always_comb begin
        v1_next   = ang_u[31:4];
        ulo1_next = ang_u[3:0];
        p1_next   = v1_next * tsvr_pkg::RECIP225;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            v1_reg   <= v1_next;
            ulo1_reg <= ulo1_next;
            p1_reg   <= p1_next;
            x1_reg   <= x_in;
            y1_reg   <= y_in;
        end
    end

    // ---------------- stage 2: remainder, sine and cosine angles ----------------
    logic [20:0]                q1;
    logic [27:0]                q225;
    logic [27:0]                r225;
    logic [tsvr_pkg::RED_W-1:0] rem;
    logic [tsvr_pkg::RED_W:0]   redc_wide;
    logic [tsvr_pkg::RED_W-1:0] red2_reg, red2_next;
    logic [tsvr_pkg::RED_W-1:0] redc2_reg, redc2_next;
    logic signed [W-1:0]        x2_reg, y2_reg;

    always_comb begin
        q1   = p1_reg[56:tsvr_pkg::RECIP225_SH];
        q225 = {7'd0, q1} * tsvr_pkg::DIV225;
        r225 = v1_reg - q225;
        rem  = {r225[7:0], ulo1_reg};
        // undo the 2^31 offset
        if (rem >= tsvr_pkg::RED_OFS) begin
            red2_next = rem - tsvr_pkg::RED_OFS;
        end else begin
            red2_next = rem + tsvr_pkg::RED_WRAP;
        end
        // cosine angle (900 - r) mod 3600, taken straight from rem
        if (rem <= tsvr_pkg::COS_SHIFT) begin
            redc_wide = {1'b0, tsvr_pkg::COS_SHIFT - rem};
        end else begin
            redc_wide = tsvr_pkg::COS_SHIFT_HI - {1'b0, rem};
        end
        redc2_next = redc_wide[tsvr_pkg::RED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            red2_reg  <= red2_next;
            redc2_reg <= redc2_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
        end
    end

    // ---------------- stage 3: quadrant fold, degree / tenth split ----------------
    tsvr_pkg::trig_idx_t sidx3_reg, sidx3_next;
    tsvr_pkg::trig_idx_t cidx3_reg, cidx3_next;
    logic signed [W-1:0] x3_reg, y3_reg;

    always_comb begin
        sidx3_next = tsvr_pkg::split_angle(red2_reg);
        cidx3_next = tsvr_pkg::split_angle(redc2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sidx3_reg <= sidx3_next;
            cidx3_reg <= cidx3_next;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
        end
    end

    // ---------------- stage 4: table lookup and tenth product ----------------
    logic [tsvr_pkg::ROM_W-1:0] sbase4_reg, sbase4_next, cbase4_reg, cbase4_next;
    logic [tsvr_pkg::LIN_W-1:0] slin4_reg, slin4_next, clin4_reg, clin4_next;
    logic                       sneg4_reg, cneg4_reg;
    logic signed [W-1:0]        x4_reg, y4_reg;

    always_comb begin
        sbase4_next = tsvr_pkg::COS_ROM[tsvr_pkg::LAST_DEG - sidx3_reg.deg];
        cbase4_next = tsvr_pkg::COS_ROM[tsvr_pkg::LAST_DEG - cidx3_reg.deg];
        slin4_next  = tsvr_pkg::LIN_W'(sidx3_reg.tenth)
                    * tsvr_pkg::LIN_W'(tsvr_pkg::COS_ROM[sidx3_reg.deg]);
        clin4_next  = tsvr_pkg::LIN_W'(cidx3_reg.tenth)
                    * tsvr_pkg::LIN_W'(tsvr_pkg::COS_ROM[cidx3_reg.deg]);
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sbase4_reg <= sbase4_next;
            cbase4_reg <= cbase4_next;
            slin4_reg  <= slin4_next;
            clin4_reg  <= clin4_next;
            sneg4_reg  <= sidx3_reg.neg;
            cneg4_reg  <= cidx3_reg.neg;
            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
        end
    end

    // ---------------- stage 5: (lin + 286) / 573 by reciprocal ----------------
    logic [33:0]                sp5_reg, sp5_next, cp5_reg, cp5_next;
    logic [tsvr_pkg::ROM_W-1:0] sbase5_reg, cbase5_reg;
    logic                       sneg5_reg, cneg5_reg;
    logic signed [W-1:0]        x5_reg, y5_reg;

    always_comb begin
        sp5_next = 34'(slin4_reg + tsvr_pkg::LIN_RND) * 34'(tsvr_pkg::LIN_RECIP);
        cp5_next = 34'(clin4_reg + tsvr_pkg::LIN_RND) * 34'(tsvr_pkg::LIN_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            sp5_reg    <= sp5_next;
            cp5_reg    <= cp5_next;
            sbase5_reg <= sbase4_reg;
            cbase5_reg <= cbase4_reg;
            sneg5_reg  <= sneg4_reg;
            cneg5_reg  <= cneg4_reg;
            x5_reg     <= x4_reg;
            y5_reg     <= y4_reg;
        end
    end

    // ---------------- stage 6: magnitude and sign ----------------
    logic [tsvr_pkg::TRIG_W-1:0]        smag, cmag;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin6_reg, sin6_next, cos6_reg, cos6_next;
    logic signed [W-1:0]                x6_reg, y6_reg;

    always_comb begin
        smag      = tsvr_pkg::TRIG_W'(sbase5_reg)
                  + tsvr_pkg::TRIG_W'(sp5_reg[33:tsvr_pkg::LIN_SH]);
        cmag      = tsvr_pkg::TRIG_W'(cbase5_reg)
                  + tsvr_pkg::TRIG_W'(cp5_reg[33:tsvr_pkg::LIN_SH]);
        sin6_next = sneg5_reg ? -$signed(smag) : $signed(smag);
        cos6_next = cneg5_reg ? -$signed(cmag) : $signed(cmag);
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            sin6_reg <= sin6_next;
            cos6_reg <= cos6_next;
            x6_reg   <= x5_reg;
            y6_reg   <= y5_reg;
        end
    end

    // ---------------- stage 7: rotation products ----------------
    logic signed [PW-1:0]               cx7_reg, cx7_next, sy7_reg, sy7_next;
    logic signed [PW-1:0]               sx7_reg, sx7_next, cy7_reg, cy7_next;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin7_reg, cos7_reg;

    always_comb begin
        cx7_next = cos6_reg * x6_reg;
        sy7_next = sin6_reg * y6_reg;
        sx7_next = sin6_reg * x6_reg;
        cy7_next = cos6_reg * y6_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            cx7_reg  <= cx7_next;
            sy7_reg  <= sy7_next;
            sx7_reg  <= sx7_next;
            cy7_reg  <= cy7_next;
            sin7_reg <= sin6_reg;
            cos7_reg <= cos6_reg;
        end
    end

    // ---------------- stage 8: sums ----------------
    logic signed [SW-1:0]               nx8_reg, nx8_next, ny8_reg, ny8_next;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin8_reg, cos8_reg;

    always_comb begin
        nx8_next = SW'(cx7_reg) - SW'(sy7_reg);
        ny8_next = SW'(sx7_reg) + SW'(cy7_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            nx8_reg  <= nx8_next;
            ny8_reg  <= ny8_next;
            sin8_reg <= sin7_reg;
            cos8_reg <= cos7_reg;
        end
    end

    // ---------------- stage 9: sign / magnitude, drop factor 16 ----------------
    logic signed [SW-1:0]               nx_abs, ny_abs;
    logic [VW-1:0]                      xv9_reg, xv9_next, yv9_reg, yv9_next;
    logic                               xneg9_reg, yneg9_reg;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin9_reg, cos9_reg;

    always_comb begin
        nx_abs   = nx8_reg[SW-1] ? -nx8_reg : nx8_reg;
        ny_abs   = ny8_reg[SW-1] ? -ny8_reg : ny8_reg;
        xv9_next = nx_abs[MAG_W-1:4];
        yv9_next = ny_abs[MAG_W-1:4];
    end

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            xv9_reg   <= xv9_next;
            yv9_reg   <= yv9_next;
            xneg9_reg <= nx8_reg[SW-1];
            yneg9_reg <= ny8_reg[SW-1];
            sin9_reg  <= sin8_reg;
            cos9_reg  <= cos8_reg;
        end
    end

    // ---------------- stage 10: partial products of /625 reciprocal ----------------
    logic [VL+RL-1:0]                   xll10_reg, xll10_next, yll10_reg, yll10_next;
    logic [VL+RH-1:0]                   xlh10_reg, xlh10_next, ylh10_reg, ylh10_next;
    logic [VH+RL-1:0]                   xhl10_reg, xhl10_next, yhl10_reg, yhl10_next;
    logic [VH+RH-1:0]                   xhh10_reg, xhh10_next, yhh10_reg, yhh10_next;
    logic                               xneg10_reg, yneg10_reg;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin10_reg, cos10_reg;

    always_comb begin
        xll10_next = xv9_reg[VL-1:0]  * RECIP[RL-1:0];
        xlh10_next = xv9_reg[VL-1:0]  * RECIP[RW-1:RL];
        xhl10_next = xv9_reg[VW-1:VL] * RECIP[RL-1:0];
        xhh10_next = xv9_reg[VW-1:VL] * RECIP[RW-1:RL];
        yll10_next = yv9_reg[VL-1:0]  * RECIP[RL-1:0];
        ylh10_next = yv9_reg[VL-1:0]  * RECIP[RW-1:RL];
        yhl10_next = yv9_reg[VW-1:VL] * RECIP[RL-1:0];
        yhh10_next = yv9_reg[VW-1:VL] * RECIP[RW-1:RL];
    end

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            xll10_reg  <= xll10_next;
            xlh10_reg  <= xlh10_next;
            xhl10_reg  <= xhl10_next;
            xhh10_reg  <= xhh10_next;
            yll10_reg  <= yll10_next;
            ylh10_reg  <= ylh10_next;
            yhl10_reg  <= yhl10_next;
            yhh10_reg  <= yhh10_next;
            xneg10_reg <= xneg9_reg;
            yneg10_reg <= yneg9_reg;
            sin10_reg  <= sin9_reg;
            cos10_reg  <= cos9_reg;
        end
    end

    // ---------------- stage 11: combine partial products ----------------
    logic [PRW-1:0]                     xprod11_reg, xprod11_next, yprod11_reg, yprod11_next;
    logic                               xneg11_reg, yneg11_reg;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin11_reg, cos11_reg;

    always_comb begin
        xprod11_next = PRW'(xll10_reg) + (PRW'(xlh10_reg) << RL)
                     + (PRW'(xhl10_reg) << VL) + (PRW'(xhh10_reg) << (VL + RL));
        yprod11_next = PRW'(yll10_reg) + (PRW'(ylh10_reg) << RL)
                     + (PRW'(yhl10_reg) << VL) + (PRW'(yhh10_reg) << (VL + RL));
    end

    always_ff @(posedge aclk) begin
        if (en[11]) begin
            xprod11_reg <= xprod11_next;
            yprod11_reg <= yprod11_next;
            xneg11_reg  <= xneg10_reg;
            yneg11_reg  <= yneg10_reg;
            sin11_reg   <= sin10_reg;
            cos11_reg   <= cos10_reg;
        end
    end

    // ---------------- stage 12: quotient, sign, output register ----------------
    logic [QX-1:0]                      xq_ext, yq_ext;
    logic [QX-1:0]                      xres, yres;
    logic [tsvr_pkg::XY_OUT_W-1:0]      xo12_reg, xo12_next, yo12_reg, yo12_next;
    logic signed [tsvr_pkg::TRIG_W-1:0] sin12_reg, cos12_reg;

    always_comb begin
        xq_ext    = QX'(xprod11_reg[PRW-1:K_DIV]);
        yq_ext    = QX'(yprod11_reg[PRW-1:K_DIV]);
        xres      = xneg11_reg ? -xq_ext : xq_ext;
        yres      = yneg11_reg ? -yq_ext : yq_ext;
        xo12_next = xres[tsvr_pkg::XY_OUT_W-1:0];
        yo12_next = yres[tsvr_pkg::XY_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[12]) begin
            xo12_reg  <= xo12_next;
            yo12_reg  <= yo12_next;
            sin12_reg <= sin11_reg;
            cos12_reg <= cos11_reg;
        end
    end

    assign m_tdata = {2'b00, cos12_reg, sin12_reg, yo12_reg, xo12_reg};

    // ---------------- assertions ----------------
    `ASSERT_NEVER(a_red_range, aclk, aresetn,
        vld_reg[2] && (red2_reg >= tsvr_pkg::FULL_TURN || redc2_reg >= tsvr_pkg::FULL_TURN))
    `ASSERT_NEVER(a_idx_range, aclk, aresetn,
        vld_reg[3] && (sidx3_reg.deg > tsvr_pkg::LAST_DEG
                       || sidx3_reg.tenth > tsvr_pkg::LAST_TENTH
                       || cidx3_reg.deg > tsvr_pkg::LAST_DEG
                       || cidx3_reg.tenth > tsvr_pkg::LAST_TENTH))
    `ASSERT_NEVER(a_trig_range, aclk, aresetn,
        vld_reg[6] && (sin6_reg > tsvr_pkg::TRIG_MAX || sin6_reg < -tsvr_pkg::TRIG_MAX
                       || cos6_reg > tsvr_pkg::TRIG_MAX || cos6_reg < -tsvr_pkg::TRIG_MAX))
    `ASSERT_PROP(a_item_count, aclk, aresetn,
        $past(aresetn) |-> ($countones(vld_reg) ==
            $past($countones(vld_reg)) + $past(in_acc) - $past(out_acc)))

endmodule
